FILE: src/hcbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hcbd_pkg;

  // body framing modes
  localparam logic [1:0] MODE_RAW     = 2'd0;
  localparam logic [1:0] MODE_FIXED   = 2'd1;
  localparam logic [1:0] MODE_CHUNKED = 2'd2;

  // configuration register indexes
  localparam logic REG_BODY_MODE      = 1'b0;
  localparam logic REG_CONTENT_LENGTH = 1'b1;

  localparam int unsigned MODE_W = 2;
  localparam int unsigned LEN_W  = 48;
  localparam int unsigned BYTE_W = 8;

  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_0  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_9  = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_UA = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UF = 8'h46;
  localparam logic [BYTE_W-1:0] CHAR_LA = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LF_HEX = 8'h66;
  localparam logic [3:0]        HEX_TEN = 4'd10;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_CHUNK_HDR  = 3'd1,
    ERR_FOOTER     = 3'd2,
    ERR_TRAILER    = 3'd3,
    ERR_OVERFLOW   = 3'd4,
    ERR_AFTER_END  = 3'd5
  } err_e;

  typedef enum logic [13:0] {
    PH_SZ_FIRST = 14'h0001,
    PH_SZ_MORE  = 14'h0002,
    PH_EXT      = 14'h0004,
    PH_HDR_LF   = 14'h0008,
    PH_DATA     = 14'h0010,
    PH_FT_CR    = 14'h0020,
    PH_FT_LF    = 14'h0040,
    PH_TR_START = 14'h0080,
    PH_TR_LINE  = 14'h0100,
    PH_TR_LF    = 14'h0200,
    PH_END_LF   = 14'h0400,
    PH_DONE     = 14'h0800,
    PH_RUN      = 14'h1000,
    PH_ERR      = 14'h2000
  } phase_e;

  typedef struct packed {
    phase_e phase;
    err_e   err;
  } ctl_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // ascii hex digit decode, either letter case
  function automatic hex_t hex_decode(input logic [BYTE_W-1:0] b);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (b >= CHAR_0 && b <= CHAR_9) begin
      h.ok  = 1'b1;
      h.val = 4'(b - CHAR_0);
    end else if (b >= CHAR_UA && b <= CHAR_UF) begin
      h.ok  = 1'b1;
      h.val = 4'(b - CHAR_UA) + HEX_TEN;
    end else if (b >= CHAR_LA && b <= CHAR_LF_HEX) begin
      h.ok  = 1'b1;
      h.val = 4'(b - CHAR_LA) + HEX_TEN;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

FILE: src/hcbd_step.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbd_step #(
  parameter int unsigned COUNT_BITS = 48
) (
  input  hcbd_pkg::ctl_t                  ctl_i,
  input  logic [COUNT_BITS-1:0]           rem_i,
  input  logic [hcbd_pkg::MODE_W-1:0]     mode_i,
  input  logic [hcbd_pkg::BYTE_W-1:0]     byte_i,
  output hcbd_pkg::ctl_t                  ctl_o,
  output logic [COUNT_BITS-1:0]           rem_o,
  output logic                            pay_o
);
  import hcbd_pkg::*;

  localparam logic [COUNT_BITS-1:0] One = COUNT_BITS'(1);

  hex_t                  hex;
  logic [COUNT_BITS-1:0] rem_dec;
  logic                  is_cr;
  logic                  is_lf;

  assign hex     = hex_decode(byte_i);
  assign rem_dec = rem_i - One;
  assign is_cr   = (byte_i == CHAR_CR);
  assign is_lf   = (byte_i == CHAR_LF);

  always_comb begin
    ctl_o = ctl_i;
    rem_o = rem_i;
    pay_o = 1'b0;
    if (ctl_i.err == ERR_NONE) begin
      unique case (ctl_i.phase)
        PH_RUN: begin
          pay_o = 1'b1;
          if (mode_i == MODE_FIXED) begin
            rem_o = rem_dec;
            if (rem_dec == '0) ctl_o.phase = PH_DONE;
          end
        end
        PH_DONE: begin
          ctl_o.err = ERR_AFTER_END;
        end
        PH_SZ_FIRST, PH_SZ_MORE: begin
          if (hex.ok) begin
            if (rem_i[COUNT_BITS-1 -: 4] != 4'd0) begin
              ctl_o.err   = ERR_OVERFLOW;
              ctl_o.phase = PH_ERR;
            end else begin
              rem_o       = {rem_i[COUNT_BITS-5:0], hex.val};
              ctl_o.phase = PH_SZ_MORE;
            end
          end else if (ctl_i.phase == PH_SZ_FIRST) begin
            ctl_o.err   = ERR_CHUNK_HDR;
            ctl_o.phase = PH_ERR;
          end else begin
            ctl_o.phase = is_cr ? PH_HDR_LF : PH_EXT;
          end
        end
        PH_EXT: begin
          if (is_cr) ctl_o.phase = PH_HDR_LF;
        end
        PH_HDR_LF: begin
          if (!is_lf) begin
            ctl_o.err   = ERR_CHUNK_HDR;
            ctl_o.phase = PH_ERR;
          end else begin
            ctl_o.phase = (rem_i == '0) ? PH_TR_START : PH_DATA;
          end
        end
        PH_DATA: begin
          pay_o = 1'b1;
          rem_o = rem_dec;
          if (rem_dec == '0) ctl_o.phase = PH_FT_CR;
        end
        PH_FT_CR: begin
          if (!is_cr) begin
            ctl_o.err   = ERR_FOOTER;
            ctl_o.phase = PH_ERR;
          end else begin
            ctl_o.phase = PH_FT_LF;
          end
        end
        PH_FT_LF: begin
          if (!is_lf) begin
            ctl_o.err   = ERR_FOOTER;
            ctl_o.phase = PH_ERR;
          end else begin
            ctl_o.phase = PH_SZ_FIRST;
          end
        end
        PH_TR_START: begin
          ctl_o.phase = is_cr ? PH_END_LF : PH_TR_LINE;
        end
        PH_TR_LINE: begin
          if (is_cr) ctl_o.phase = PH_TR_LF;
        end
        PH_TR_LF: begin
          if (!is_lf) begin
            ctl_o.err   = ERR_TRAILER;
            ctl_o.phase = PH_ERR;
          end else begin
            ctl_o.phase = PH_TR_START;
          end
        end
        PH_END_LF: begin
          if (!is_lf) begin
            ctl_o.err   = ERR_TRAILER;
            ctl_o.phase = PH_ERR;
          end else begin
            ctl_o.phase = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/http_chunked_body_deframer.sv
`timescale 1ns / 1ps
`default_nettype none

// http reply body deframer. one byte enters per transaction and one result leaves per
// transaction: the byte echoed, a payload flag, an end-of-body flag and the sticky error
// code. a byte is taken every clock while the output side keeps up; each byte goes through the
// combinational parser (decode plus one 48 bit count step) and then sits in the output
// register, which frees itself in the cycle it is taken, so in_stall_o rises only when a
// finished result is held back by out_stall_i. body_mode selects raw (0, also 3),
// fixed length (1) or chunked (2). any register write restarts the parser in the new mode;
// write only while no transaction is in flight. COUNT_BITS sets the width of the chunk
// size and length counter; a content_length that does not fit saturates.

module http_chunked_body_deframer #(
  parameter int unsigned COUNT_BITS = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // byte input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [hcbd_pkg::BYTE_W-1:0]   in_byte_i,
  // result output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [hcbd_pkg::BYTE_W-1:0]   out_byte_o,
  output logic                          payload_valid_o,
  output logic                          body_done_o,
  output logic [2:0]                    error_code_o,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic                          cfg_addr_i,
  input  logic [hcbd_pkg::LEN_W-1:0]    cfg_wdata_i
);
  import hcbd_pkg::*;

  // configuration registers
  logic [MODE_W-1:0]     mode_q;
  logic [LEN_W-1:0]      len_q;
  logic [MODE_W-1:0]     mode_wr;
  logic [LEN_W-1:0]      len_wr;
  logic [COUNT_BITS-1:0] len_sat;

  // parser state
  ctl_t                  ctl_q, ctl_d, ctl_rst;
  logic [COUNT_BITS-1:0] rem_q, rem_d, rem_rst;
  logic                  pay;

  // output register
  logic                  out_valid_q;
  logic [BYTE_W-1:0]     out_byte_q;
  logic                  pay_q;
  logic                  done_q;
  err_e                  err_q;

  logic                  in_acc;

  // output register frees in the same cycle it is taken
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  // register values as they stand after a write this cycle
  assign mode_wr = (cfg_addr_i == REG_BODY_MODE)      ? cfg_wdata_i[MODE_W-1:0] : mode_q;
  assign len_wr  = (cfg_addr_i == REG_CONTENT_LENGTH) ? cfg_wdata_i : len_q;

  // fit content_length into the counter, saturating when it is too wide
  generate
    if (COUNT_BITS > LEN_W) begin : g_len_ext
      assign len_sat = {{(COUNT_BITS-LEN_W){1'b0}}, len_wr};
    end else if (COUNT_BITS == LEN_W) begin : g_len_eq
      assign len_sat = len_wr;
    end else begin : g_len_sat
      assign len_sat = (len_wr[LEN_W-1:COUNT_BITS] != '0) ? '1 : len_wr[COUNT_BITS-1:0];
    end
  endgenerate

  // restart state for the mode being written
  always_comb begin
    ctl_rst.err = ERR_NONE;
    rem_rst     = '0;
    if (mode_wr == MODE_CHUNKED) begin
      ctl_rst.phase = PH_SZ_FIRST;
    end else if (mode_wr == MODE_FIXED) begin
      rem_rst       = len_sat;
      ctl_rst.phase = (len_sat == '0) ? PH_DONE : PH_RUN;
    end else begin
      ctl_rst.phase = PH_RUN;
    end
  end

  hcbd_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .ctl_i  (ctl_q),
    .rem_i  (rem_q),
    .mode_i (mode_q),
    .byte_i (in_byte_i),
    .ctl_o  (ctl_d),
    .rem_o  (rem_d),
    .pay_o  (pay)
  );

  // config and parser state; a write restarts the parser
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_CHUNKED;
      len_q       <= '0;
      ctl_q.phase <= PH_SZ_FIRST;
      ctl_q.err   <= ERR_NONE;
      rem_q       <= '0;
    end else if (cfg_we_i) begin
      mode_q <= mode_wr;
      len_q  <= len_wr;
      ctl_q  <= ctl_rst;
      rem_q  <= rem_rst;
    end else if (in_acc) begin
      ctl_q <= ctl_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_byte_q <= in_byte_i;
      pay_q      <= pay;
      done_q     <= (ctl_d.phase == PH_DONE);
      err_q      <= ctl_d.err;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign payload_valid_o = pay_q;
  assign body_done_o     = done_q;
  assign error_code_o    = err_q;

endmodule

`default_nettype wire

FILE: src/hcbd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbd_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       out_valid_o,
  input  logic       out_stall_i,
  input  logic [7:0] out_byte_o,
  input  logic       payload_valid_o,
  input  logic       body_done_o,
  input  logic [2:0] error_code_o
);
  import hcbd_pkg::*;

  // a held result keeps its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(payload_valid_o) && $stable(error_code_o))
    else $error("stalled result changed");

  // payload only while no error is latched
  a_pay_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && payload_valid_o |-> error_code_o == ERR_NONE)
    else $error("payload byte reported with an error");

  // a byte after the end keeps the body ended
  a_after_end_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o == ERR_AFTER_END |-> body_done_o && !payload_valid_o)
    else $error("byte after end without body done");

endmodule

bind http_chunked_body_deframer hcbd_checker u_hcbd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_byte_o      (out_byte_o),
  .payload_valid_o (payload_valid_o),
  .body_done_o     (body_done_o),
  .error_code_o    (error_code_o)
);

`default_nettype wire

FILE: sim/tb_http_chunked_body_deframer.sv
`timescale 1ns / 1ps

module tb_http_chunked_body_deframer;
  import hcbd_pkg::*;

  localparam int unsigned CNT_W       = 48;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_BYTES = 1600;
  localparam int unsigned HOLD_CYCLES = 150;
  // mode value 3 is decoded as raw
  localparam logic [1:0]        MODE_ALIAS_RAW = 2'd3;
  localparam logic [BYTE_W-1:0] CHAR_SEMI      = 8'h3B;
  localparam logic [BYTE_W-1:0] CHAR_SPACE     = 8'h20;

  // one deframed byte as it leaves the block
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              pay;
    logic              done;
    err_e              err;
  } frame_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] res_byte;
  logic              res_pay;
  logic              res_done;
  logic [2:0]        res_err;
  logic              cfg_we = 1'b0;
  logic              cfg_addr = 1'b0;
  logic [LEN_W-1:0]  cfg_wdata = '0;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  http_chunked_body_deframer #(
    .COUNT_BITS (CNT_W)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .in_byte_i       (in_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .out_byte_o      (res_byte),
    .payload_valid_o (res_pay),
    .body_done_o     (res_done),
    .error_code_o    (res_err),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  // ------------------------------------------------------------------
  // deframer model: own copy of the registers and the parse state
  // ------------------------------------------------------------------
  logic [MODE_W-1:0] mdl_mode;
  logic [LEN_W-1:0]  mdl_len;
  phase_e            mdl_phase;
  logic [CNT_W-1:0]  mdl_left;
  err_e              mdl_err;
  logic [7:0]        err_seen = '0;

  // any register write puts the parser back at the start of a body
  function automatic void restart_deframer();
    mdl_err  = ERR_NONE;
    mdl_left = '0;
    if (mdl_mode == MODE_CHUNKED) begin
      mdl_phase = PH_SZ_FIRST;
    end else if (mdl_mode == MODE_FIXED) begin
      // counter is as wide as the register, so no saturation case here
      mdl_left  = mdl_len;
      mdl_phase = (mdl_len == '0) ? PH_DONE : PH_RUN;
    end else begin
      mdl_phase = PH_RUN;
    end
  endfunction

  // first error sticks; a byte after the end keeps the done flag up
  function automatic void trip(input err_e code);
    mdl_err        = code;
    mdl_phase      = (code == ERR_AFTER_END) ? PH_DONE : PH_ERR;
    err_seen[code] = 1'b1;
  endfunction

  function automatic frame_t deframe_byte(input logic [BYTE_W-1:0] b);
    frame_t     f;
    logic [3:0] nib;
    logic       is_hex;
    f.data = b;
    f.pay  = 1'b0;
    is_hex = 1'b1;
    nib    = 4'd0;
    // digits carry their value in the low nibble, letters of either case start at 1
    if (b >= CHAR_0 && b <= CHAR_9) begin
      nib = b[3:0];
    end else if ((b >= CHAR_UA && b <= CHAR_UF) || (b >= CHAR_LA && b <= CHAR_LF_HEX)) begin
      nib = b[3:0] + (HEX_TEN - 4'd1);
    end else begin
      is_hex = 1'b0;
    end
    if (mdl_err == ERR_NONE) begin
      case (mdl_phase)
        PH_RUN: begin
          f.pay = 1'b1;
          if (mdl_mode == MODE_FIXED) begin
            mdl_left = mdl_left - 1'b1;
            if (mdl_left == '0) mdl_phase = PH_DONE;
          end
        end
        PH_DONE: trip(ERR_AFTER_END);
        PH_SZ_FIRST, PH_SZ_MORE: begin
          if (is_hex) begin
            // a full top nibble means the next digit would not fit
            if (mdl_left[CNT_W-1 -: 4] != 4'd0) begin
              trip(ERR_OVERFLOW);
            end else begin
              mdl_left  = {mdl_left[CNT_W-5:0], nib};
              mdl_phase = PH_SZ_MORE;
            end
          end else if (mdl_phase == PH_SZ_FIRST) begin
            trip(ERR_CHUNK_HDR);
          end else if (b == CHAR_CR) begin
            mdl_phase = PH_HDR_LF;
          end else begin
            mdl_phase = PH_EXT;
          end
        end
        PH_EXT: if (b == CHAR_CR) mdl_phase = PH_HDR_LF;
        PH_HDR_LF: begin
          if (b != CHAR_LF) trip(ERR_CHUNK_HDR);
          else if (mdl_left == '0) mdl_phase = PH_TR_START;
          else mdl_phase = PH_DATA;
        end
        PH_DATA: begin
          f.pay    = 1'b1;
          mdl_left = mdl_left - 1'b1;
          if (mdl_left == '0) mdl_phase = PH_FT_CR;
        end
        PH_FT_CR: if (b != CHAR_CR) trip(ERR_FOOTER); else mdl_phase = PH_FT_LF;
        PH_FT_LF: if (b != CHAR_LF) trip(ERR_FOOTER); else mdl_phase = PH_SZ_FIRST;
        PH_TR_START: begin
          if (b == CHAR_CR) mdl_phase = PH_END_LF;
          else mdl_phase = PH_TR_LINE;
        end
        PH_TR_LINE: if (b == CHAR_CR) mdl_phase = PH_TR_LF;
        PH_TR_LF: if (b != CHAR_LF) trip(ERR_TRAILER); else mdl_phase = PH_TR_START;
        PH_END_LF: if (b != CHAR_LF) trip(ERR_TRAILER); else mdl_phase = PH_DONE;
        default: ;
      endcase
    end
    f.done = (mdl_phase == PH_DONE);
    f.err  = mdl_err;
    return f;
  endfunction

  // ------------------------------------------------------------------
  // shared bookkeeping
  // ------------------------------------------------------------------
  logic [BYTE_W-1:0] tx_bytes[$];          // bytes waiting for the driver
  frame_t            predicted_frames[$];  // results owed by the block
  int unsigned       n_queued = 0;
  int unsigned       n_accepted = 0;
  int unsigned       n_checked = 0;
  int unsigned       n_bad = 0;
  int unsigned       n_payload = 0;
  int unsigned       n_cycles = 0;
  int unsigned       tx_style = 0;         // 0 streams back to back, else gaps between bursts, longest at 3
  int unsigned       rx_style = 0;         // 0 adds no stalls of its own, else one of three patterns

  always @(posedge clk) n_cycles <= n_cycles + 1;

  // ------------------------------------------------------------------
  // driver: offers bytes in bursts, predicts each byte the block takes
  // ------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin : drive_bytes
    logic   take;
    frame_t fr;
    if (rst_n) begin
      take = in_valid && !in_stall;
      if (take) begin
        fr               = deframe_byte(in_byte);
        predicted_frames = {predicted_frames, fr};
        n_accepted++;
      end
      // a byte that is offered stays put until it is taken
      if (!in_valid || take) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (tx_bytes.size() != 0) begin
          in_valid <= 1'b1;
          in_byte  <= tx_bytes.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = (tx_style == 0) ? 0 : $urandom_range(1, (tx_style == 3) ? 12 : 4);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // monitor: checks each result in order and drives the output stall
  // ------------------------------------------------------------------
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 500;

  always @(posedge clk) begin : check_results
    frame_t want;
    frame_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.data = res_byte;
        got.pay  = res_pay;
        got.done = res_done;
        got.err  = err_e'(res_err);
        if (predicted_frames.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("[%0t] result %0d unexpected: byte %02h pay %b done %b err %0d",
                     $time, n_checked, got.data, got.pay, got.done, got.err);
        end else begin
          want = predicted_frames.pop_front();
          if (got !== want) begin
            n_bad++;
            if (n_bad <= 10)
              $display("[%0t] result %0d exp %02h/%b/%b/%0d got %02h/%b/%b/%0d",
                       $time, n_checked, want.data, want.pay, want.done, want.err,
                       got.data, got.pay, got.done, got.err);
          end
        end
        if (got.pay === 1'b1) n_payload++;
        n_checked++;
      end
      // long hold-off while bytes keep coming, so the input side has to stall
      if (hold_left == 0 && in_valid && n_checked >= next_hold_at) begin
        hold_left    = HOLD_CYCLES;
        next_hold_at = next_hold_at + 600;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (rx_style)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= (n_cycles % 3 == 0);
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------
  logic [BYTE_W-1:0] seg[$];   // body segment under construction

  function automatic void seg_add(input logic [BYTE_W-1:0] b);
    seg = {seg, b};
  endfunction

  function automatic logic [BYTE_W-1:0] any_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // free text inside extensions and trailer lines, never a cr
  function automatic logic [BYTE_W-1:0] text_byte();
    logic [BYTE_W-1:0] b;
    b = any_byte();
    if (b == CHAR_CR) b = CHAR_SPACE;
    return b;
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) seg_add(s[i]);
  endfunction

  function automatic void add_crlf();
    seg_add(CHAR_CR);
    seg_add(CHAR_LF);
  endfunction

  // chunk size in hex, each letter in a random case, with optional leading zeros
  function automatic void add_hex(input logic [LEN_W-1:0] v, input int lead);
    int                nd;
    logic [LEN_W-1:0]  sh;
    logic [3:0]        nib;
    nd = 1;
    while (nd < 12 && (v >> (4 * nd)) != '0) nd++;
    for (int i = nd + lead - 1; i >= 0; i--) begin
      sh  = v >> (4 * i);
      nib = sh[3:0];
      if (nib < HEX_TEN) seg_add(CHAR_0 + nib);
      else if ($urandom_range(0, 1)) seg_add(CHAR_UA + (nib - HEX_TEN));
      else seg_add(CHAR_LA + (nib - HEX_TEN));
    end
  endfunction

  function automatic void add_ext();
    seg_add(CHAR_SEMI);
    repeat ($urandom_range(0, 5)) seg_add(text_byte());
  endfunction

  // one chunked body: mostly well formed, some damaged, some pure noise
  function automatic void build_chunked();
    int kind;
    int size;
    int pos;
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      // twelve digits with a nonzero lead fill the counter, the next one overflows
      add_hex({4'($urandom_range(1, 15)), 44'({$urandom, $urandom})}, $urandom_range(0, 1));
      repeat ($urandom_range(1, 2)) add_hex(LEN_W'($urandom_range(0, 15)), 0);
      add_crlf();
      repeat (3) seg_add(any_byte());
    end else if (kind < 10) begin
      // largest size that still fits, only the start of its data
      add_hex('1, $urandom_range(0, 2));
      add_crlf();
      repeat (6) seg_add(any_byte());
    end else if (kind < 15) begin
      repeat (16) seg_add(any_byte());
    end else begin
      repeat ($urandom_range(0, 3)) begin
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        add_hex(LEN_W'(size), int'($urandom_range(0, 3) == 0));
        if ($urandom_range(0, 3) == 0) add_ext();
        add_crlf();
        repeat (size) seg_add(any_byte());
        add_crlf();
      end
      // last chunk, trailer lines, empty line
      add_hex('0, $urandom_range(0, 2));
      if ($urandom_range(0, 3) == 0) add_ext();
      add_crlf();
      repeat ($urandom_range(0, 2)) begin
        repeat ($urandom_range(1, 6)) seg_add(text_byte());
        add_crlf();
      end
      add_crlf();
      repeat ($urandom_range(0, 2)) seg_add(any_byte());
      if ($urandom_range(0, 9) < 3) begin
        pos      = $urandom_range(0, seg.size() - 1);
        seg[pos] = any_byte();
      end
    end
  endfunction

  // wait until every queued byte is taken and every result is back
  task automatic settle();
    @(negedge clk);
    while (n_queued != n_accepted || predicted_frames.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // hand the segment to the driver; a split one drains fully half way through
  task automatic send_segment(input bit split);
    int cut;
    cut = split ? seg.size() / 2 : seg.size();
    @(negedge clk);
    foreach (seg[i]) begin
      if (i == cut) begin
        settle();
        @(negedge clk);
      end
      tx_bytes = {tx_bytes, seg[i]};
      n_queued++;
    end
    seg.delete();
  endtask

  // register write, only while the block is idle
  task automatic write_reg(input logic idx, input logic [LEN_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BODY_MODE) mdl_mode = val[MODE_W-1:0];
    else mdl_len = val;
    restart_deframer();
  endtask

  // ------------------------------------------------------------------
  // test sequence
  // ------------------------------------------------------------------
  int unsigned n_segments = 0;
  int unsigned n_random = 0;

  initial begin : run_sequence
    int               pick;
    logic [1:0]       mode;
    logic [LEN_W-1:0] len;
    mdl_mode = MODE_CHUNKED;
    mdl_len  = '0;
    restart_deframer();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset mode: one chunk with an extension, a trailer line, then a byte past the end
    add_text("1;x");
    add_crlf();
    add_text("Z");
    add_crlf();
    add_text("0");
    add_crlf();
    add_text("T");
    add_crlf();
    add_crlf();
    add_text("!");
    send_segment(1'b0);
    settle();
    // fixed length zero ends at once, so any byte is past the end
    write_reg(REG_BODY_MODE, LEN_W'(MODE_FIXED));
    write_reg(REG_CONTENT_LENGTH, '0);
    seg_add(8'hFF);
    send_segment(1'b0);
    settle();
    // mode 3 acts as raw whatever the length says
    write_reg(REG_CONTENT_LENGTH, '1);
    write_reg(REG_BODY_MODE, LEN_W'(MODE_ALIAS_RAW));
    seg_add(8'h00);
    seg_add(8'hFF);
    send_segment(1'b0);
    settle();
    // chunk header with no size digit, then a byte under the latched error
    write_reg(REG_BODY_MODE, LEN_W'(MODE_CHUNKED));
    add_text("g");
    seg_add(CHAR_CR);
    send_segment(1'b0);
    settle();

    // random segments, each under a fresh mode and length
    while (n_random < RANDOM_BYTES) begin
      tx_style = $urandom_range(0, 3);
      rx_style = $urandom_range(0, 3);
      pick     = $urandom_range(0, 9);
      if (pick < 6) mode = MODE_CHUNKED;
      else if (pick < 8) mode = MODE_FIXED;
      else if (pick == 8) mode = MODE_RAW;
      else mode = MODE_ALIAS_RAW;
      pick = $urandom_range(0, 9);
      if (pick == 0) len = '0;
      else if (pick == 1) len = '1;
      else if (pick == 2) len = LEN_W'({$urandom, $urandom});
      else len = LEN_W'($urandom_range(1, 40));
      if ($urandom_range(0, 1)) begin
        write_reg(REG_BODY_MODE, LEN_W'(mode));
        write_reg(REG_CONTENT_LENGTH, len);
      end else begin
        write_reg(REG_CONTENT_LENGTH, len);
        write_reg(REG_BODY_MODE, LEN_W'(mode));
      end
      if (mode == MODE_CHUNKED) begin
        build_chunked();
      end else if (mode == MODE_FIXED) begin
        // run a little past the end of short bodies
        if (len <= 40) repeat (int'(len) + $urandom_range(0, 3)) seg_add(any_byte());
        else repeat ($urandom_range(10, 30)) seg_add(any_byte());
      end else begin
        repeat ($urandom_range(10, 40)) seg_add(any_byte());
      end
      n_random += seg.size();
      send_segment(n_segments % 5 == 0 && seg.size() > 4);
      n_segments++;
      settle();
    end

    settle();
    repeat (10) @(posedge clk);
    $display("deframer run: %0d bytes checked (%0d random over %0d segments), %0d payload",
             n_checked, n_random, n_segments, n_payload);
    $display("error codes reached (one bit per code): %b", err_seen);
    if (n_bad == 0 && predicted_frames.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog on the cycle counter
  initial begin : watchdog
    wait (n_cycles >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

endmodule
